// ===== sv/bmp332_pkg.sv =====
package bmp332_pkg;

  // file layout
  localparam int unsigned HDR_BYTES   = 14;
  localparam int unsigned INFO_BYTES  = 40;
  localparam logic [31:0] HEADER_END  = 32'(HDR_BYTES + INFO_BYTES);

  // little-endian header fields, first and last byte of each
  localparam logic [31:0] OFS_FIRST   = 32'd10;
  localparam logic [31:0] OFS_LAST    = 32'd13;
  localparam logic [31:0] WID_FIRST   = 32'd18;
  localparam logic [31:0] WID_LAST    = 32'd21;
  localparam logic [31:0] HGT_FIRST   = 32'd22;
  localparam logic [31:0] HGT_LAST    = 32'd25;
  // all three fields start at an address that is 2 mod 4
  localparam logic [1:0]  FIELD_LANE0 = 2'd2;

  localparam logic [7:0]  TOP3_MASK   = 8'hE0;
  localparam logic [1:0]  PAD_MASK    = 2'h3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd2;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  color;
    logic        last_pixel;
  } pix_t;

endpackage

// ===== sv/bmp332_parser.sv =====
module bmp332_parser #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         file_byte_i,
  input  logic               start_of_file_i,
  input  logic [15:0]        origin_x_i,
  input  logic [15:0]        origin_y_i,
  output logic               pix_valid_o,
  output bmp332_pkg::pix_t   pix_o
);
  import bmp332_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_e;

  phase_e              phase_q, phase_d, phase_b;
  logic [31:0]         cnt_q, cnt_d, cnt_b, cnt_inc;
  logic [31:0]         off_q, off_d, off_b;
  logic [DIM_BITS-1:0] width_q, width_d, width_b;
  logic [DIM_BITS-1:0] height_q, height_d, height_b;
  logic [1:0]          bip_q, bip_d, bip_b;
  logic [7:0]          blue_q, blue_d, blue_b;
  logic [7:0]          green_q, green_d, green_b;
  logic [DIM_BITS-1:0] col_q, col_d, col_b, col_inc;
  logic [DIM_BITS-1:0] row_q, row_d, row_b, row_inc;
  logic [1:0]          pad_q, pad_d, pad_b;
  logic [1:0]          lane;
  logic [31:0]         byte_shifted;

  function automatic phase_e enter_data(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
    phase_e ph;
    ph = ((w == '0) || (h == '0)) ? PH_DONE : PH_PIXEL;
    return ph;
  endfunction

  always_comb begin
    // start mark clears the parse before this byte is seen
    phase_b  = start_of_file_i ? PH_HEADER : phase_q;
    cnt_b    = start_of_file_i ? '0 : cnt_q;
    off_b    = start_of_file_i ? '0 : off_q;
    width_b  = start_of_file_i ? '0 : width_q;
    height_b = start_of_file_i ? '0 : height_q;
    bip_b    = start_of_file_i ? '0 : bip_q;
    blue_b   = start_of_file_i ? '0 : blue_q;
    green_b  = start_of_file_i ? '0 : green_q;
    col_b    = start_of_file_i ? '0 : col_q;
    row_b    = start_of_file_i ? '0 : row_q;
    pad_b    = start_of_file_i ? '0 : pad_q;

    phase_d  = phase_b;
    cnt_d    = cnt_b;
    off_d    = off_b;
    width_d  = width_b;
    height_d = height_b;
    bip_d    = bip_b;
    blue_d   = blue_b;
    green_d  = green_b;
    col_d    = col_b;
    row_d    = row_b;
    pad_d    = pad_b;

    cnt_inc      = cnt_b + 32'd1;
    col_inc      = col_b + 1'b1;
    row_inc      = row_b + 1'b1;
    lane         = cnt_b[1:0] - FIELD_LANE0;
    byte_shifted = 32'(file_byte_i) << {lane, 3'b000};

    pix_valid_o      = 1'b0;
    pix_o.color      = (file_byte_i & TOP3_MASK) | ((green_b & TOP3_MASK) >> 3)
                     | ((blue_b & TOP3_MASK) >> 6);
    pix_o.pos_x      = origin_x_i + 16'(col_b);
    pix_o.pos_y      = origin_y_i + 16'(height_b) - 16'd1 - 16'(row_b);
    pix_o.last_pixel = 1'b0;

    unique case (phase_b)
      PH_HEADER: begin
        if (cnt_b >= OFS_FIRST && cnt_b <= OFS_LAST) begin
          off_d = off_b | byte_shifted;
        end else if (cnt_b >= WID_FIRST && cnt_b <= WID_LAST) begin
          width_d = DIM_BITS'(32'(width_b) | byte_shifted);
        end else if (cnt_b >= HGT_FIRST && cnt_b <= HGT_LAST) begin
          height_d = DIM_BITS'(32'(height_b) | byte_shifted);
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= HEADER_END) begin
          if (off_d > HEADER_END) begin
            phase_d = PH_SKIP;
          end else begin
            phase_d = enter_data(width_d, height_d);
          end
        end
      end
      PH_SKIP: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= off_b) begin
          phase_d = enter_data(width_b, height_b);
        end
      end
      PH_PAD: begin
        pad_d = pad_b - 2'd1;
        if (pad_d == 2'd0) begin
          phase_d = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        if (bip_b == 2'd0) begin
          blue_d = file_byte_i;
          bip_d  = 2'd1;
        end else if (bip_b == 2'd1) begin
          green_d = file_byte_i;
          bip_d   = 2'd2;
        end else begin
          // red byte closes the pixel
          pix_valid_o = 1'b1;
          bip_d       = 2'd0;
          col_d       = col_inc;
          if (col_inc == width_b) begin
            col_d = '0;
            row_d = row_inc;
            if (row_inc == height_b) begin
              phase_d          = PH_DONE;
              pix_o.last_pixel = 1'b1;
            end else if ((width_b[1:0] & PAD_MASK) != 2'd0) begin
              pad_d   = width_b[1:0] & PAD_MASK;
              phase_d = PH_PAD;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      cnt_q    <= '0;
      off_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      bip_q    <= '0;
      blue_q   <= '0;
      green_q  <= '0;
      col_q    <= '0;
      row_q    <= '0;
      pad_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      off_q    <= off_d;
      width_q  <= width_d;
      height_q <= height_d;
      bip_q    <= bip_d;
      blue_q   <= blue_d;
      green_q  <= green_d;
      col_q    <= col_d;
      row_q    <= row_d;
      pad_q    <= pad_d;
    end
  end

endmodule

// ===== sv/bmp_rgb24_to_rgb332_writer_unit.sv =====
// channel   direction  handshake               payload
// in        input      in_valid_i/in_ready_o   file_byte_i, start_of_file_i
// out       output     out_valid_o/out_ready_i base_addr_o, pos_x_o, pos_y_o, color_o,
//                                              last_pixel_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one file byte per cycle while in_ready_o is high; a pixel write is offered in the cycle after its red byte is taken
// the latency is the single result register behind the parse logic
// in_ready_o drops only while a finished write is held and out_ready_i is low
// reset is asynchronous and active low; it clears the parse state, the configuration
// registers and the write valid
// cfg_ready_o is always high; a write to an index past the list is dropped
module bmp_rgb24_to_rgb332_writer_unit #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // byte stream in
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         file_byte_i,
  input  logic                               start_of_file_i,
  // pixel writes out
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        base_addr_o,
  output logic [15:0]                        pos_x_o,
  output logic [15:0]                        pos_y_o,
  output logic [7:0]                         color_o,
  output logic                               last_pixel_o,
  // register writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bmp332_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);
  import bmp332_pkg::*;

  logic        in_xfer;
  logic        pix_valid;
  pix_t        pix;

  logic [31:0] frame_base_q;
  logic [15:0] origin_x_q;
  logic [15:0] origin_y_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] base_addr_q;
  pix_t        pix_q;

  // the result register frees up in the same cycle it is drained
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  bmp332_parser #(
    .DIM_BITS(DIM_BITS)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_xfer),
    .file_byte_i    (file_byte_i),
    .start_of_file_i(start_of_file_i),
    .origin_x_i     (origin_x_q),
    .origin_y_i     (origin_y_q),
    .pix_valid_o    (pix_valid),
    .pix_o          (pix)
  );

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= '0;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_BASE: frame_base_q <= cfg_data_i;
        CFG_ORIGIN_X:   origin_x_q   <= cfg_data_i[15:0];
        CFG_ORIGIN_Y:   origin_y_q   <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // result register: loaded by a byte transfer that closes a pixel
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = pix_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload carries no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer && pix_valid) begin
      base_addr_q <= frame_base_q;
      pix_q       <= pix;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign base_addr_o  = base_addr_q;
  assign pos_x_o      = pix_q.pos_x;
  assign pos_y_o      = pix_q.pos_y;
  assign color_o      = pix_q.color;
  assign last_pixel_o = pix_q.last_pixel;

endmodule

// ===== sv/bmp332_checker.sv =====
module bmp332_props (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [7:0]                       file_byte_i,
  input logic                             start_of_file_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [31:0]                      base_addr_o,
  input logic [15:0]                      pos_x_o,
  input logic [15:0]                      pos_y_o,
  input logic [7:0]                       color_o,
  input logic                             last_pixel_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [bmp332_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [31:0]                      cfg_data_i
);

  // a stalled write holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(base_addr_o) && $stable(pos_x_o)
      && $stable(pos_y_o) && $stable(color_o) && $stable(last_pixel_o))
    else $error("pixel write changed while stalled");

  // an empty result register never blocks the byte stream
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no pending write");

  // a held, stalled write blocks new bytes
  a_block_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while a write is stalled");

  // a write appears only after a byte transfer
  a_write_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("pixel write without a byte transfer");

endmodule

bind bmp_rgb24_to_rgb332_writer_unit bmp332_props u_bmp332_props (.*);
